>>> sv/slc_pkg.sv
`default_nettype none

package slc_pkg;

  // Field widths of the two channels and the timeout register
  localparam int ACTION_W    = 2;
  localparam int PRIM_W      = 3;
  localparam int TAG_W       = 16;
  localparam int TIMEOUT_W   = 16;

  // Hold queue: default depth, and reset value of the timeout register
  localparam int HOLD_DEPTH_DFLT = 8;
  localparam logic [TIMEOUT_W-1:0] TIMEOUT_RST = 16'd1000;

  // Input action codes
  localparam logic [ACTION_W-1:0] ACT_MESSAGE   = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_PRIMITIVE = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_TICK      = 2'd2;

  // Link primitive codes
  localparam logic [PRIM_W-1:0] PRIM_EST_REQ  = 3'd0;
  localparam logic [PRIM_W-1:0] PRIM_EST_IND  = 3'd1;
  localparam logic [PRIM_W-1:0] PRIM_EST_CONF = 3'd2;
  localparam logic [PRIM_W-1:0] PRIM_REL_REQ  = 3'd3;
  localparam logic [PRIM_W-1:0] PRIM_REL_IND  = 3'd4;
  localparam logic [PRIM_W-1:0] PRIM_REL_CONF = 3'd5;
  localparam logic [PRIM_W-1:0] PRIM_EST_ERR  = 3'd6;

  // Result kinds and sides
  localparam logic KIND_MESSAGE   = 1'b0;
  localparam logic KIND_PRIMITIVE = 1'b1;
  localparam logic SIDE_A         = 1'b0;
  localparam logic SIDE_B         = 1'b1;

  typedef enum logic [1:0] {
    LINK_RELEASED    = 2'd0,
    LINK_AWAIT_EST   = 2'd1,
    LINK_AWAIT_REL   = 2'd2,
    LINK_ESTABLISHED = 2'd3
  } link_state_t;

  typedef enum logic [1:0] {
    SEQ_IDLE,
    SEQ_EXEC,
    SEQ_FLUSH
  } seq_state_t;

  // Commands to the establish timer
  typedef struct packed {
    logic start;
    logic stop;
    logic tick;
  } tmr_cmd_t;

endpackage

`default_nettype wire

>>> sv/slc_in_if.sv
`default_nettype none

interface slc_in_if;
  import slc_pkg::*;

  logic                valid;
  logic                ready;
  logic [ACTION_W-1:0] action;
  logic                arrived_from;
  logic [PRIM_W-1:0]   primitive_req;
  logic [TAG_W-1:0]    message_tag;

  modport source (
    output valid, action, arrived_from, primitive_req, message_tag,
    input  ready
  );

  modport sink (
    input  valid, action, arrived_from, primitive_req, message_tag,
    output ready
  );

endinterface

`default_nettype wire

>>> sv/slc_out_if.sv
`default_nettype none

interface slc_out_if;
  import slc_pkg::*;

  logic              valid;
  logic              ready;
  logic              out_kind;
  logic              out_side;
  logic [PRIM_W-1:0] out_primitive;
  logic [TAG_W-1:0]  out_tag;
  logic              last;

  modport source (
    output valid, out_kind, out_side, out_primitive, out_tag, last,
    input  ready
  );

  modport sink (
    input  valid, out_kind, out_side, out_primitive, out_tag, last,
    output ready
  );

endinterface

`default_nettype wire

>>> sv/slc_hold_mem.sv
`default_nettype none

module slc_hold_mem #(
  parameter int DEPTH = slc_pkg::HOLD_DEPTH_DFLT,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  parameter int DW    = slc_pkg::TAG_W + 1
) (
  input  wire logic          clk,
  input  wire logic          wr_en,
  input  wire logic [AW-1:0] wr_addr,
  input  wire logic [DW-1:0] wr_data,
  input  wire logic          rd_en,
  input  wire logic [AW-1:0] rd_addr,
  output logic      [DW-1:0] rd_data_r
);

  logic [DW-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read port; data holds until the next read
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

>>> sv/slc_est_timer.sv
`default_nettype none

module slc_est_timer (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic [slc_pkg::TIMEOUT_W-1:0]   timeout,
  input  wire slc_pkg::tmr_cmd_t               cmd,
  output logic                                 expire
);
  import slc_pkg::*;

  logic                 running_r, running_nxt;
  logic [TIMEOUT_W-1:0] count_r, count_nxt;

  // a running timer with one or fewer ticks left expires on the next tick
  assign expire = running_r && (count_r <= TIMEOUT_W'(1));

  always_comb begin
    running_nxt = running_r;
    count_nxt   = count_r;
    if (cmd.start) begin
      running_nxt = 1'b1;
      count_nxt   = timeout;
    end else if (cmd.stop || (cmd.tick && expire)) begin
      running_nxt = 1'b0;
      count_nxt   = '0;
    end else if (cmd.tick && running_r) begin
      count_nxt = count_r - TIMEOUT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      running_r <= 1'b0;
      count_r   <= '0;
    end else begin
      running_r <= running_nxt;
      count_r   <= count_nxt;
    end
  end

  // commands come from one decoded item, never two at once
  a_cmd_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.start, cmd.stop, cmd.tick}))
    else $error("timer got more than one command");

  // an idle timer has a cleared count
  a_idle_zero: assert property (@(posedge clk) disable iff (!rst_n)
    !running_r |-> count_r == '0)
    else $error("stopped timer holds a count");

  // expiry leaves the timer stopped
  a_expire_stops: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.tick && expire && !cmd.start) |=> !running_r)
    else $error("timer still running after expiry");

endmodule

`default_nettype wire

>>> sv/signalling_link_coordinator.sv
`default_nettype none

// Signalling link coordinator.
// in_if carries one transaction per item: a signalling message, a link
// primitive or a timer tick. out_if carries the resulting transactions,
// with last set on the final one of each item; an item may give none.
// cfg_we/cfg_wdata write the establish timeout; the user is to write it
// only while the block is idle, a rule that the block itself leaves unenforced.
// An item is captured on acceptance and executed in SEQ_EXEC once the output
// register is free, its first result going into the output register. An
// item that establishes the link then drains up to HOLD_DEPTH held messages
// from the memory read port, one per cycle while the output register is free.
// Reset: link released, timer stopped, hold queue empty, timeout 1000.
// The queue memory needs no clearing; entries are read only once written.
// A stalled receiver holds the output register; execution and the flush
// wait on it and no result is dropped. in_if.ready is high only when the
// previous item is fully done.
module signalling_link_coordinator #(
  parameter int HOLD_DEPTH = slc_pkg::HOLD_DEPTH_DFLT
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  slc_in_if.sink                             in_if,
  slc_out_if.source                          out_if,
  input  wire logic                          cfg_we,
  input  wire logic [slc_pkg::TIMEOUT_W-1:0] cfg_wdata
);
  import slc_pkg::*;

  localparam int AW = (HOLD_DEPTH > 1) ? $clog2(HOLD_DEPTH) : 1;
  localparam int CW = $clog2(HOLD_DEPTH + 1);
  localparam int DW = TAG_W + 1;

  // timeout register
  logic [TIMEOUT_W-1:0] timeout_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timeout_r <= TIMEOUT_RST;
    end else if (cfg_we) begin
      timeout_r <= cfg_wdata;
    end
  end

  // sequencer and link state
  seq_state_t  seq_r, seq_nxt;
  link_state_t link_r, link_nxt;

  // captured item
  logic [ACTION_W-1:0] item_act_r;
  logic                item_from_r;
  logic [PRIM_W-1:0]   item_prim_r;
  logic [TAG_W-1:0]    item_tag_r;

  // hold queue pointers
  logic [AW-1:0] head_r, tail_r, head_inc, tail_inc;
  logic [CW-1:0] hold_cnt_r;

  // output register
  logic              out_valid_r;
  logic              out_kind_r, out_side_r, out_last_r;
  logic [PRIM_W-1:0] out_prim_r;
  logic [TAG_W-1:0]  out_tag_r;
  logic              out_free;

  // decode results
  logic              emit, e_kind, e_side, e_last;
  logic [PRIM_W-1:0] e_prim;
  logic [TAG_W-1:0]  e_tag;
  logic              push, pop, flush, other;
  tmr_cmd_t          tcmd;
  logic              tmr_expire;

  // memory port
  logic          mem_rd_en;
  logic [AW-1:0] mem_rd_addr;
  logic [DW-1:0] mem_rd_data;

  assign in_if.ready = (seq_r == SEQ_IDLE);
  assign out_free    = !out_valid_r || out_if.ready;
  assign other       = ~item_from_r;
  assign head_inc    = (head_r == AW'(HOLD_DEPTH - 1)) ? '0 : head_r + AW'(1);
  assign tail_inc    = (tail_r == AW'(HOLD_DEPTH - 1)) ? '0 : tail_r + AW'(1);

  // next state, results and queue/timer commands
  always_comb begin
    seq_nxt  = seq_r;
    link_nxt = link_r;
    emit     = 1'b0;
    e_kind   = KIND_PRIMITIVE;
    e_side   = SIDE_A;
    e_prim   = '0;
    e_tag    = '0;
    e_last   = 1'b0;
    push     = 1'b0;
    pop      = 1'b0;
    flush    = 1'b0;
    tcmd     = '0;
    case (seq_r)
      SEQ_IDLE: begin
        if (in_if.valid) begin
          seq_nxt = SEQ_EXEC;
        end
      end
      SEQ_EXEC: begin
        if (out_free) begin
          if (item_act_r == ACT_TICK) begin
            tcmd.tick = 1'b1;
            if (tmr_expire &&
                (link_r == LINK_RELEASED || link_r == LINK_AWAIT_EST)) begin
              emit   = 1'b1;
              e_side = SIDE_A;
              e_prim = PRIM_EST_ERR;
            end
          end else if (item_act_r == ACT_MESSAGE || item_act_r == ACT_PRIMITIVE) begin
            case (link_r)
              LINK_RELEASED: begin
                if (item_act_r == ACT_MESSAGE || item_prim_r == PRIM_EST_REQ) begin
                  // hold the message if there is room, then ask for the link
                  push       = (item_act_r == ACT_MESSAGE) &&
                               (hold_cnt_r < CW'(HOLD_DEPTH));
                  link_nxt   = LINK_AWAIT_EST;
                  tcmd.start = 1'b1;
                  emit       = 1'b1;
                  e_side     = SIDE_B;
                  e_prim     = PRIM_EST_REQ;
                end else if (item_prim_r == PRIM_EST_IND) begin
                  link_nxt = LINK_ESTABLISHED;
                  emit     = 1'b1;
                  e_side   = other;
                  e_prim   = item_prim_r;
                end
              end
              LINK_AWAIT_EST: begin
                if (item_act_r == ACT_PRIMITIVE) begin
                  if (item_prim_r == PRIM_EST_CONF || item_prim_r == PRIM_EST_IND) begin
                    tcmd.stop = 1'b1;
                    link_nxt  = LINK_ESTABLISHED;
                    emit      = 1'b1;
                    e_side    = other;
                    e_prim    = item_prim_r;
                  end else if (item_prim_r == PRIM_REL_IND) begin
                    link_nxt = LINK_RELEASED;
                    emit     = 1'b1;
                    e_side   = other;
                    e_prim   = item_prim_r;
                  end
                end
              end
              LINK_AWAIT_REL: begin
                if (item_act_r == ACT_PRIMITIVE && item_prim_r == PRIM_REL_CONF) begin
                  link_nxt = LINK_RELEASED;
                  emit     = 1'b1;
                  e_side   = other;
                  e_prim   = item_prim_r;
                end
              end
              LINK_ESTABLISHED: begin
                if (item_act_r == ACT_MESSAGE) begin
                  emit   = 1'b1;
                  e_kind = KIND_MESSAGE;
                  e_side = other;
                  e_tag  = item_tag_r;
                end else if (item_prim_r == PRIM_REL_REQ) begin
                  link_nxt = LINK_AWAIT_REL;
                  emit     = 1'b1;
                  e_side   = other;
                  e_prim   = item_prim_r;
                end else if (item_prim_r == PRIM_REL_IND) begin
                  link_nxt = LINK_RELEASED;
                  emit     = 1'b1;
                  e_side   = other;
                  e_prim   = item_prim_r;
                end else if (item_prim_r == PRIM_EST_IND ||
                             item_prim_r == PRIM_EST_CONF) begin
                  emit   = 1'b1;
                  e_side = other;
                  e_prim = item_prim_r;
                end else if (item_prim_r == PRIM_EST_REQ) begin
                  // bounced back to A as a confirm
                  emit   = 1'b1;
                  e_side = SIDE_A;
                  e_prim = PRIM_EST_CONF;
                end
              end
              default: begin
              end
            endcase
          end
          flush   = (link_nxt == LINK_ESTABLISHED) && (hold_cnt_r != '0);
          e_last  = !flush;
          seq_nxt = flush ? SEQ_FLUSH : SEQ_IDLE;
        end
      end
      SEQ_FLUSH: begin
        // one held message per cycle while the output register is free, back toward the far side
        if (out_free) begin
          pop    = 1'b1;
          emit   = 1'b1;
          e_kind = KIND_MESSAGE;
          e_side = ~mem_rd_data[TAG_W];
          e_tag  = mem_rd_data[TAG_W-1:0];
          e_last = (hold_cnt_r == CW'(1));
          if (hold_cnt_r == CW'(1)) begin
            seq_nxt = SEQ_IDLE;
          end
        end
      end
      default: begin
        seq_nxt = SEQ_IDLE;
      end
    endcase
  end

  // read the head when a flush starts, and the next entry on each pop but the last;
  // a push never shares a cycle with a read, so no forwarding is needed
  assign mem_rd_en   = flush || (pop && hold_cnt_r > CW'(1));
  assign mem_rd_addr = pop ? head_inc : head_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seq_r      <= SEQ_IDLE;
      link_r     <= LINK_RELEASED;
      head_r     <= '0;
      tail_r     <= '0;
      hold_cnt_r <= '0;
    end else begin
      seq_r  <= seq_nxt;
      link_r <= link_nxt;
      if (push) begin
        tail_r     <= tail_inc;
        hold_cnt_r <= hold_cnt_r + CW'(1);
      end else if (pop) begin
        head_r     <= head_inc;
        hold_cnt_r <= hold_cnt_r - CW'(1);
      end
    end
  end

  // item capture on an accepted transaction
  always_ff @(posedge clk) begin
    if (in_if.valid && in_if.ready) begin
      item_act_r  <= in_if.action;
      item_from_r <= in_if.arrived_from;
      item_prim_r <= in_if.primitive_req;
      item_tag_r  <= in_if.message_tag;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit) begin
      out_valid_r <= 1'b1;
    end else if (out_if.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_kind_r <= e_kind;
      out_side_r <= e_side;
      out_prim_r <= e_prim;
      out_tag_r  <= e_tag;
      out_last_r <= e_last;
    end
  end

  assign out_if.valid         = out_valid_r;
  assign out_if.out_kind      = out_kind_r;
  assign out_if.out_side      = out_side_r;
  assign out_if.out_primitive = out_prim_r;
  assign out_if.out_tag       = out_tag_r;
  assign out_if.last          = out_last_r;

  slc_est_timer u_timer (
    .clk     (clk),
    .rst_n   (rst_n),
    .timeout (timeout_r),
    .cmd     (tcmd),
    .expire  (tmr_expire)
  );

  slc_hold_mem #(
    .DEPTH (HOLD_DEPTH),
    .AW    (AW),
    .DW    (DW)
  ) u_hold_mem (
    .clk       (clk),
    .wr_en     (push),
    .wr_addr   (tail_r),
    .wr_data   ({item_from_r, item_tag_r}),
    .rd_en     (mem_rd_en),
    .rd_addr   (mem_rd_addr),
    .rd_data_r (mem_rd_data)
  );

  // queue fill never exceeds its depth
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    hold_cnt_r <= CW'(HOLD_DEPTH))
    else $error("hold queue overfilled");

  // flushing only happens on an established link with messages held
  a_flush_ok: assert property (@(posedge clk) disable iff (!rst_n)
    seq_r == SEQ_FLUSH |-> link_r == LINK_ESTABLISHED && hold_cnt_r != '0)
    else $error("flush without established link or held messages");

  // a message is held only when the link moves to awaiting establish
  a_push_ok: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> seq_r == SEQ_EXEC && link_nxt == LINK_AWAIT_EST)
    else $error("message held outside the release path");

  // the queue is empty once a flush completes
  a_flush_drains: assert property (@(posedge clk) disable iff (!rst_n)
    (seq_r == SEQ_FLUSH && seq_nxt == SEQ_IDLE) |=> hold_cnt_r == '0)
    else $error("flush ended with messages left");

endmodule

`default_nettype wire
